### design/wafl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wafl_pkg;

    // Default sizes
    localparam int STORE_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int TIME_BITS_DEF   = 32;

    // Fixed widths
    localparam int CFG_BITS  = 11;
    localparam int CFG_IDX_W = 2;
    localparam int RES_BITS  = 32;
    localparam int FRAC_BITS = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM     = 2'd2;

    // Memory read address source
    localparam logic [1:0] RD_SLOT   = 2'd0;
    localparam logic [1:0] RD_NEWEST = 2'd1;
    localparam logic [1:0] RD_SWEEP  = 2'd2;

    // Wide products of the fit
    localparam logic [1:0] MUL_NSXX  = 2'd0;
    localparam logic [1:0] MUL_SXSX  = 2'd1;
    localparam logic [1:0] MUL_SYSXX = 2'd2;
    localparam logic [1:0] MUL_SXSXY = 2'd3;

    // Divider operand selection
    localparam logic [1:0] DIV_AVG = 2'd0;
    localparam logic [1:0] DIV_ONE = 2'd1;
    localparam logic [1:0] DIV_FIT = 2'd2;
    localparam logic [1:0] DIV_DEG = 2'd3;

    typedef struct packed {
        logic       accept;
        logic [1:0] rd_sel;
        logic       update;
        logic       res_last;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_take;
        logic       sweep_start;
        logic       sweep;
        logic       mul_start;
        logic       mul_take;
        logic [1:0] mul_op;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic act_alg;
        logic frozen;
        logic multi;
        logic sweep_done;
        logic mul_done;
        logic div_done;
        logic den_pos;
    } t_sts;

endpackage

`default_nettype wire

### design/wafl_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier, one multiplier bit a cycle; stops once the
// remaining multiplier bits are zero.
module wafl_mul #(
    parameter int PW = 74
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [PW-1:0]   i_a,
    input  wire logic [PW-1:0]   i_b,
    output logic                 o_done,
    output logic [2*PW-1:0]      o_prod
);

    logic [2*PW-1:0] r_acc;
    logic [2*PW-1:0] r_a;
    logic [PW-1:0]   r_b;
    logic            r_busy;
    logic            r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_b == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= (2*PW)'(i_a);
            r_b   <= i_b;
        end else if (r_busy && r_b != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[2*PW-2:0], 1'b0};
            r_b <= {1'b0, r_b[PW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

### design/wafl_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: round(256 * num / den), ties away from zero,
// saturated to the signed result width. One quotient bit a cycle.
module wafl_div #(
    parameter int WW = 149
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [WW-1:0]                     i_mag,
    input  wire logic                              i_neg,
    input  wire logic [WW-1:0]                     i_den,
    output logic                                   o_done,
    output logic signed [wafl_pkg::RES_BITS-1:0]   o_quot
);

    localparam int QW = WW + wafl_pkg::FRAC_BITS;
    localparam int KW = $clog2(QW + 1);
    localparam int RB = wafl_pkg::RES_BITS;

    logic [QW-1:0] r_dvd;
    logic [WW-1:0] r_rem;
    logic [WW-1:0] r_den;
    logic [RB-1:0] r_q;
    logic          r_ovf;
    logic          r_neg;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [WW:0]   trial;
    logic          fits;
    logic          round_up;
    logic [RB:0]   q_rnd;

    assign trial = {r_rem, r_dvd[QW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == KW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_mag, {wafl_pkg::FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_neg <= i_neg;
            r_cnt <= KW'(QW);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[QW-2:0], 1'b0};
            r_rem <= fits ? WW'(trial - {1'b0, r_den}) : WW'(trial);
            r_q   <= {r_q[RB-2:0], fits};
            r_ovf <= r_ovf | r_q[RB-1];
            r_cnt <= r_cnt - KW'(1);
        end
    end

    // Round on the remainder, then clamp to the signed range
    assign round_up = {r_rem, 1'b0} >= {1'b0, r_den};
    assign q_rnd    = {1'b0, r_q} + (RB+1)'(round_up);

    always_comb begin
        if (r_neg) begin
            if (r_ovf || q_rnd > {2'b01, {(RB-1){1'b0}}}) begin
                o_quot = {1'b1, {(RB-1){1'b0}}};
            end else begin
                o_quot = RB'(-q_rnd);
            end
        end else begin
            if (r_ovf || q_rnd > {2'b00, {(RB-1){1'b1}}}) begin
                o_quot = {1'b0, {(RB-1){1'b1}}};
            end else begin
                o_quot = RB'(q_rnd);
            end
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

### design/wafl_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module wafl_dp #(
    parameter int STORE_DEPTH = wafl_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = wafl_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = wafl_pkg::TIME_BITS_DEF,
    parameter int CB          = $clog2(STORE_DEPTH + 1)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [wafl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [wafl_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_sample_value,
    input  wire logic [TIME_BITS-1:0]                i_sample_time,
    input  wire logic                                i_restart,
    input  wire wafl_pkg::t_cmd                      i_cmd,
    output wafl_pkg::t_sts                           o_sts,
    output logic signed [wafl_pkg::RES_BITS-1:0]     o_result_value,
    output logic [CB-1:0]                            o_fill_count,
    output logic                                     o_filling,
    output logic                                     o_fit_degenerate
);

    localparam int SB   = SAMPLE_BITS;
    localparam int TB   = TIME_BITS;
    localparam int AB   = $clog2(STORE_DEPTH);
    localparam int SUMW = SB + CB;
    localparam int SXW  = TB + CB;
    localparam int XXW  = 2 * TB;
    localparam int SXXW = 2 * TB + CB;
    localparam int XYW  = TB + SB + 1;
    localparam int SXYW = TB + SB + CB;
    localparam int PW   = (SXYW > SXXW) ? SXYW : SXXW;
    localparam int WW   = 2 * PW + 1;
    localparam int RB   = wafl_pkg::RES_BITS;

    // Configuration
    logic [wafl_pkg::CFG_BITS-1:0] r_wl;
    logic                          r_run_mode;
    logic                          r_alg_sel;

    // Window state
    logic [AB-1:0]          r_slot;
    logic [CB-1:0]          r_cnt;
    logic signed [SUMW-1:0] r_sum;
    logic [CB-1:0]          r_act_len;
    logic                   r_act_alg;
    logic signed [RB-1:0]   r_last;

    // Stores
    logic signed [SB-1:0] smem [STORE_DEPTH];
    logic [TB-1:0]        tmem [STORE_DEPTH];
    logic signed [SB-1:0] r_rd_s;
    logic [TB-1:0]        r_rd_t;
    logic [AB-1:0]        rd_addr;
    logic                 mem_we;

    // Item
    logic signed [SB-1:0] r_s;
    logic [TB-1:0]        r_t;
    logic                 r_filling;
    logic                 r_frozen;
    logic                 r_deg;
    logic signed [RB-1:0] r_res;

    // Fit
    logic [TB-1:0]          r_newest;
    logic [CB-1:0]          r_idx;
    logic                   r_v1, r_v2, r_v3;
    logic [TB-1:0]          r_dx, r_dx3;
    logic signed [SB-1:0]   r_y;
    logic [XXW-1:0]         r_xx;
    logic signed [XYW-1:0]  r_xy;
    logic [SXW-1:0]         r_sx;
    logic [SXXW-1:0]        r_sxx;
    logic signed [SXYW-1:0] r_sxy;
    logic signed [WW-1:0]   r_p1;
    logic signed [WW-1:0]   r_den;
    logic signed [WW-1:0]   r_num;
    logic                   issue;

    // Arithmetic units
    logic [PW-1:0]        mul_a, mul_b;
    logic                 mul_neg;
    logic                 mul_done;
    logic [2*PW-1:0]      mul_prod;
    logic signed [WW-1:0] prod_s;
    logic signed [WW-1:0] div_num;
    logic [WW-1:0]        div_den;
    logic [WW-1:0]        div_mag;
    logic                 div_done;
    logic signed [RB-1:0] div_quot;
    logic [1:0]           r_dsel;

    logic [CB-1:0]        len_c;
    logic                 clr;
    logic                 full;
    logic [AB-1:0]        slot_nx;
    logic [AB-1:0]        newest_slot;
    logic [SUMW-1:0]      sum_mag;
    logic [SXYW-1:0]      sxy_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl       <= wafl_pkg::CFG_BITS'(1);
            r_run_mode <= 1'b0;
            r_alg_sel  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wafl_pkg::CFG_WINDOW_LENGTH: r_wl <= i_cfg_data;
                wafl_pkg::CFG_RUN_MODE:      r_run_mode <= i_cfg_data[0];
                wafl_pkg::CFG_ALGORITHM:     r_alg_sel <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_wl == '0) begin
            len_c = CB'(1);
        end else if (32'(r_wl) > 32'(STORE_DEPTH)) begin
            len_c = CB'(STORE_DEPTH);
        end else begin
            len_c = CB'(r_wl);
        end
    end

    assign clr  = i_restart || (r_alg_sel != r_act_alg) ||
                  (len_c != r_act_len && !r_run_mode);
    assign full = r_cnt >= r_act_len;
    assign slot_nx = (CB'(r_slot) + CB'(1) == r_act_len) ? '0 : r_slot + AB'(1);
    assign newest_slot = (r_slot == '0) ? AB'(r_act_len - CB'(1)) : r_slot - AB'(1);
    assign mem_we = i_cmd.update && !(full && r_run_mode);
    assign issue  = i_cmd.sweep && (r_idx < r_cnt);

    always_comb begin
        unique case (i_cmd.rd_sel)
            wafl_pkg::RD_NEWEST: rd_addr = newest_slot;
            wafl_pkg::RD_SWEEP:  rd_addr = r_idx[AB-1:0];
            default:             rd_addr = r_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            smem[r_slot] <= r_s;
            tmem[r_slot] <= r_t;
        end
        r_rd_s <= smem[rd_addr];
        r_rd_t <= tmem[rd_addr];
    end

    // Window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_act_len <= CB'(1);
            r_act_alg <= 1'b0;
            r_last    <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_act_alg <= r_alg_sel;
                if (clr) begin
                    r_slot    <= '0;
                    r_cnt     <= '0;
                    r_sum     <= '0;
                    r_last    <= '0;
                    r_act_len <= len_c;
                end
            end
            if (i_cmd.update) begin
                if (!full) begin
                    r_sum  <= r_sum + SUMW'(r_s);
                    r_cnt  <= r_cnt + CB'(1);
                    r_slot <= slot_nx;
                end else if (!r_run_mode) begin
                    r_sum  <= r_sum + SUMW'(r_s) - SUMW'(r_rd_s);
                    r_slot <= slot_nx;
                end
            end
            if (div_done && r_dsel == wafl_pkg::DIV_AVG) begin
                r_last <= div_quot;
            end
        end
    end

    // Per-item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_s       <= i_sample_value;
            r_t       <= i_sample_time;
            r_filling <= 1'b0;
            r_frozen  <= 1'b0;
            r_deg     <= 1'b0;
        end
        if (i_cmd.update) begin
            r_filling <= !full;
            r_frozen  <= full && r_run_mode;
        end
        if (i_cmd.res_last) begin
            r_res <= r_last;
        end
        if (i_cmd.div_take) begin
            r_res <= div_quot;
        end
        if (i_cmd.div_start) begin
            r_dsel <= i_cmd.div_sel;
            r_deg  <= (i_cmd.div_sel == wafl_pkg::DIV_DEG);
        end
        if (i_cmd.out_load) begin
            o_result_value   <= r_res;
            o_fill_count     <= r_cnt;
            o_filling        <= r_filling;
            o_fit_degenerate <= r_deg;
        end
    end

    // Fit sweep: read, difference, products, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_sel == wafl_pkg::RD_NEWEST) begin
            r_newest <= r_newest;
        end
        if (i_cmd.sweep_start) begin
            r_newest <= r_rd_t;
            r_idx    <= '0;
            r_sx     <= '0;
            r_sxx    <= '0;
            r_sxy    <= '0;
        end else if (issue) begin
            r_idx <= r_idx + CB'(1);
        end
        if (r_v1) begin
            r_dx <= r_newest - r_rd_t;
            r_y  <= r_rd_s;
        end
        if (r_v2) begin
            r_xx  <= XXW'(r_dx) * XXW'(r_dx);
            r_xy  <= XYW'($signed({1'b0, r_dx})) * XYW'(r_y);
            r_dx3 <= r_dx;
        end
        if (r_v3) begin
            r_sx  <= r_sx + SXW'(r_dx3);
            r_sxx <= r_sxx + SXXW'(r_xx);
            r_sxy <= r_sxy + SXYW'(r_xy);
        end
    end

    // Wide products
    assign sum_mag = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign sxy_mag = r_sxy[SXYW-1] ? SXYW'(-r_sxy) : SXYW'(r_sxy);

    always_comb begin
        unique case (i_cmd.mul_op)
            wafl_pkg::MUL_NSXX: begin
                mul_a = PW'(r_sxx); mul_b = PW'(r_cnt); mul_neg = 1'b0;
            end
            wafl_pkg::MUL_SXSX: begin
                mul_a = PW'(r_sx); mul_b = PW'(r_sx); mul_neg = 1'b0;
            end
            wafl_pkg::MUL_SYSXX: begin
                mul_a = PW'(r_sxx); mul_b = PW'(sum_mag); mul_neg = r_sum[SUMW-1];
            end
            default: begin
                mul_a = PW'(sxy_mag); mul_b = PW'(r_sx); mul_neg = r_sxy[SXYW-1];
            end
        endcase
    end

    wafl_mul #(.PW(PW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign prod_s = mul_neg ? -$signed(WW'(mul_prod)) : $signed(WW'(mul_prod));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_take) begin
            unique case (i_cmd.mul_op)
                wafl_pkg::MUL_NSXX:  r_p1  <= prod_s;
                wafl_pkg::MUL_SXSX:  r_den <= r_p1 - prod_s;
                wafl_pkg::MUL_SYSXX: r_p1  <= prod_s;
                default:             r_num <= r_p1 - prod_s;
            endcase
        end
    end

    // Divider operands
    always_comb begin
        unique case (i_cmd.div_sel)
            wafl_pkg::DIV_ONE: begin
                div_num = WW'(r_s); div_den = WW'(1);
            end
            wafl_pkg::DIV_FIT: begin
                div_num = r_num; div_den = WW'(r_den);
            end
            default: begin
                div_num = WW'(r_sum); div_den = WW'(r_cnt);
            end
        endcase
    end

    assign div_mag = div_num[WW-1] ? WW'(-div_num) : WW'(div_num);

    wafl_div #(.WW(WW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (div_mag),
        .i_neg   (div_num[WW-1]),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_sts.act_alg    = r_act_alg;
    assign o_sts.frozen     = r_frozen;
    assign o_sts.multi      = r_cnt > CB'(1);
    assign o_sts.sweep_done = (r_idx >= r_cnt) && !r_v1 && !r_v2 && !r_v3;
    assign o_sts.mul_done   = mul_done;
    assign o_sts.div_done   = div_done;
    assign o_sts.den_pos    = !r_den[WW-1] && (r_den != '0);

`ifndef ASSERT_OFF
    a_slot_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> CB'(r_slot) < r_act_len)
        else $error("write slot outside active window");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> r_cnt <= r_act_len)
        else $error("fill count above window length");
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> r_idx < r_cnt)
        else $error("sweep read beyond held points");
`endif

endmodule

`default_nettype wire

### design/wafl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wafl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  wire wafl_pkg::t_sts i_sts,
    output wafl_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_UPD  = 4'd2;
    localparam logic [3:0] S_BR   = 4'd3;
    localparam logic [3:0] S_NEW  = 4'd4;
    localparam logic [3:0] S_SWP  = 4'd5;
    localparam logic [3:0] S_MS   = 4'd6;
    localparam logic [3:0] S_MW   = 4'd7;
    localparam logic [3:0] S_FD   = 4'd8;
    localparam logic [3:0] S_DIVW = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_op, n_op;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        o_cmd       = '0;
        o_cmd.rd_sel = wafl_pkg::RD_SLOT;
        o_cmd.mul_op = r_op;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_RD: n_state = S_UPD;
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_BR;
            end
            S_BR: begin
                if (!i_sts.act_alg) begin
                    if (i_sts.frozen) begin
                        o_cmd.res_last = 1'b1;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = wafl_pkg::DIV_AVG;
                        n_state         = S_DIVW;
                    end
                end else if (!i_sts.multi) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = wafl_pkg::DIV_ONE;
                    n_state         = S_DIVW;
                end else begin
                    o_cmd.rd_sel = wafl_pkg::RD_NEWEST;
                    n_state      = S_NEW;
                end
            end
            S_NEW: begin
                o_cmd.sweep_start = 1'b1;
                n_state           = S_SWP;
            end
            S_SWP: begin
                o_cmd.sweep  = 1'b1;
                o_cmd.rd_sel = wafl_pkg::RD_SWEEP;
                if (i_sts.sweep_done) begin
                    n_op    = wafl_pkg::MUL_NSXX;
                    n_state = S_MS;
                end
            end
            S_MS: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_MW;
            end
            S_MW: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_take = 1'b1;
                    n_state        = S_MS;
                    unique case (r_op)
                        wafl_pkg::MUL_NSXX:  n_op = wafl_pkg::MUL_SXSX;
                        wafl_pkg::MUL_SXSX:  n_op = wafl_pkg::MUL_SYSXX;
                        wafl_pkg::MUL_SYSXX: n_op = wafl_pkg::MUL_SXSXY;
                        default:             n_state = S_FD;
                    endcase
                end
            end
            S_FD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = i_sts.den_pos ? wafl_pkg::DIV_FIT : wafl_pkg::DIV_DEG;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= wafl_pkg::MUL_NSXX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again before the result was built");
    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output overwritten while still held");
    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVW && i_sts.div_done) |=> r_state == S_OUT)
        else $error("quotient not passed to output");
`endif

endmodule

`default_nettype wire

### design/windowed_average_with_line_fit_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Windowed average with least-squares line fit. Each input beat carries one
// signed sample, its timestamp and a restart flag; each yields exactly one
// output beat with a signed Q.8 result, the fill count, a filling flag and a
// degenerate-fit flag. One item is worked at a time. Average mode runs the
// bit-serial divider, which makes one quotient bit a cycle (the divider width
// is 151 at default sizes), except when the window is frozen in run mode and
// the last average is reused. Fit mode with more than one held point adds a
// sweep over the held points through the sample and time memories, one read
// a cycle, then four shift-add products of the fit sums, then the divider.
// The next input beat is taken as soon as the result has moved into the
// output register, even if that is still waiting to be taken. No clearing
// pass runs after reset: the fill count keeps unwritten store entries from
// ever being used.
module windowed_average_with_line_fit_unit #(
    parameter int STORE_DEPTH = wafl_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_BITS = wafl_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = wafl_pkg::TIME_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration writes
    input  wire logic                                 i_cfg_we,
    input  wire logic [wafl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [wafl_pkg::CFG_BITS-1:0]        i_cfg_data,
    // input beats
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_sample_value,
    input  wire logic [TIME_BITS-1:0]                 i_sample_time,
    input  wire logic                                 i_restart,
    // output beats
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [wafl_pkg::RES_BITS-1:0]      o_result_value,
    output logic [$clog2(STORE_DEPTH+1)-1:0]          o_fill_count,
    output logic                                      o_filling,
    output logic                                      o_fit_degenerate
);

    localparam int CB = $clog2(STORE_DEPTH + 1);

    wafl_pkg::t_cmd cmd;
    wafl_pkg::t_sts sts;

    // Sequence each item: accept, update window, average or fit, divide unless the average is frozen, hold
    wafl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Stores, sums, products and quotient
    wafl_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS),
        .CB          (CB)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_sample_value   (i_sample_value),
        .i_sample_time    (i_sample_time),
        .i_restart        (i_restart),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_result_value   (o_result_value),
        .o_fill_count     (o_fill_count),
        .o_filling        (o_filling),
        .o_fit_degenerate (o_fit_degenerate)
    );

endmodule

`default_nettype wire
